### rtl/bgp_pkg.sv
// Shared types and constants for the one-four bond partner finder.
package bgp_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W       = 8;
  localparam int DEG_W       = 3;
  localparam int MAX_RESULTS = 36;
  localparam int CNT_W       = 6;

  // Operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Which walk register addresses a table read
  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_J = 2'd1,
    SEL_K = 2'd2
  } walk_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      latch_in;
    logic      clr_walk;
    logic      clr_all;
    logic      deg_rd;
    walk_sel_t deg_sel;
    logic      nb_rd;
    walk_sel_t nb_sel;
    logic      ld_dj;
    logic      ld_dk;
    logic      ld_dl;
    logic      ld_j;
    logic      ld_k;
    logic      inc_x;
    logic      inc_y;
    logic      inc_z;
    logic      take_l;
    logic      app_write;
    logic      push;
    logic      push_partner;
    logic      push_last;
    logic      push_status;
  } bgp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic a_ok;
    logic nb_ok;
    logic deg_full;
    logic x_more;
    logic y_more;
    logic z_more;
    logic rd_eq_a;
    logic rd_eq_j;
    logic pend_valid;
    logic out_free;
  } bgp_sts_t;

endpackage

### rtl/bgp_if.sv
// Request and response channel interfaces.
interface bgp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] atom_index;
  logic [7:0] neighbor_index;

  modport source (output valid, output operation, output atom_index,
                  output neighbor_index, input ready);
  modport sink   (input valid, input operation, input atom_index,
                  input neighbor_index, output ready);
endinterface

interface bgp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] partner_index;
  logic       found;
  logic       status;
  logic       last;

  modport source (output valid, output partner_index, output found,
                  output status, output last, input ready);
  modport sink   (input valid, input partner_index, input found,
                  input status, input last, output ready);
endinterface

### rtl/bgp_dp.sv
// Datapath: adjacency memories, walk registers, pending partner and output register.
module bgp_dp
  import bgp_pkg::*;
#(
  parameter int ATOMS      = 256,
  parameter int MAX_DEGREE = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  bgp_cmd_t         cmd,
  output bgp_sts_t         sts,
  input  logic [IDX_W-1:0] req_atom,
  input  logic [IDX_W-1:0] req_nb,
  bgp_rsp_if.source        rsp
);

  localparam int ATOM_SLOTS = (ATOMS < 256) ? ATOMS : 256;
  localparam int AW         = $clog2(ATOM_SLOTS);
  localparam int POS_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int NB_DEPTH   = ATOM_SLOTS * (2 ** POS_W);
  localparam logic [16:0]      ATOMS_L = 17'(ATOMS);
  localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);
  localparam logic [CNT_W-1:0] RES_MAX = CNT_W'(MAX_RESULTS);

  // Walk registers
  logic [IDX_W-1:0] a_q, nb_q, j_q, k_q, pend;
  logic [DEG_W-1:0] x, y, z, dj, dk, dl;
  logic [CNT_W-1:0] n;
  logic             pend_valid;

  // Memories
  logic [DEG_W-1:0]      deg_mem [ATOM_SLOTS];
  logic [ATOM_SLOTS-1:0] deg_vld;
  logic [DEG_W-1:0]      deg_rdata;
  logic                  deg_vld_rd;
  logic [IDX_W-1:0]      nb_mem [NB_DEPTH];
  logic [IDX_W-1:0]      nb_rdata;

  // Output register
  logic             out_valid;
  logic [IDX_W-1:0] out_partner;
  logic             out_found, out_status, out_last;

  logic [IDX_W-1:0]    deg_atom, nb_atom;
  logic [DEG_W-1:0]    nb_pos;
  logic [AW-1:0]       deg_addr, a_addr;
  logic [AW+POS_W-1:0] nb_raddr, nb_waddr;
  logic [DEG_W-1:0]    deg_eff;
  logic                out_free;

  // Read address selection
  always_comb begin
    case (cmd.deg_sel)
      SEL_A:   deg_atom = a_q;
      SEL_J:   deg_atom = j_q;
      default: deg_atom = k_q;
    endcase
    case (cmd.nb_sel)
      SEL_A: begin
        nb_atom = a_q;
        nb_pos  = x;
      end
      SEL_J: begin
        nb_atom = j_q;
        nb_pos  = y;
      end
      default: begin
        nb_atom = k_q;
        nb_pos  = z;
      end
    endcase
  end

  assign deg_addr = deg_atom[AW-1:0];
  assign a_addr   = a_q[AW-1:0];
  assign nb_raddr = {nb_atom[AW-1:0], nb_pos[POS_W-1:0]};
  assign deg_eff  = deg_vld_rd ? deg_rdata : '0;
  assign nb_waddr = {a_addr, deg_eff[POS_W-1:0]};
  assign out_free = !out_valid || rsp.ready;

  // Degree memory
  always_ff @(posedge clk) begin
    if (cmd.app_write) begin
      deg_mem[a_addr] <= deg_eff + DEG_W'(1);
    end
    if (cmd.deg_rd) begin
      deg_rdata  <= deg_mem[deg_addr];
      deg_vld_rd <= deg_vld[deg_addr];
    end
  end

  // Degree valid bits; an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      deg_vld <= '0;
    end else if (cmd.app_write) begin
      deg_vld[a_addr] <= 1'b1;
    end
  end

  // Neighbor table
  always_ff @(posedge clk) begin
    if (cmd.app_write) begin
      nb_mem[nb_waddr] <= nb_q;
    end
    if (cmd.nb_rd) begin
      nb_rdata <= nb_mem[nb_raddr];
    end
  end

  // Walk registers and loop counters
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_q  <= req_atom;
      nb_q <= req_nb;
    end
    if (cmd.ld_j) j_q <= nb_rdata;
    if (cmd.ld_k) k_q <= nb_rdata;
    if (cmd.ld_dj) begin
      dj <= sts.a_ok ? deg_eff : '0;
      x  <= '0;
    end else if (cmd.inc_x) begin
      x <= x + DEG_W'(1);
    end
    if (cmd.ld_dk) begin
      dk <= deg_eff;
      y  <= '0;
    end else if (cmd.inc_y) begin
      y <= y + DEG_W'(1);
    end
    if (cmd.ld_dl) begin
      dl <= deg_eff;
      z  <= '0;
    end else if (cmd.inc_z) begin
      z <= z + DEG_W'(1);
    end
    if (cmd.take_l) pend <= nb_rdata;
  end

  // Partner count and pending flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_walk) begin
      n          <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.take_l) begin
      n          <= n + CNT_W'(1);
      pend_valid <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      out_partner <= cmd.push_partner ? pend : '0;
      out_found   <= cmd.push_partner;
      out_status  <= cmd.push_partner ? 1'b0 : cmd.push_status;
      out_last    <= cmd.push_partner ? cmd.push_last : 1'b1;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.partner_index = out_partner;
  assign rsp.found         = out_found;
  assign rsp.status        = out_status;
  assign rsp.last          = out_last;

  // Status to the controller
  assign sts.a_ok       = 17'(a_q) < ATOMS_L;
  assign sts.nb_ok      = 17'(nb_q) < ATOMS_L;
  assign sts.deg_full   = deg_eff >= DEG_MAX;
  assign sts.x_more     = (x < dj) && (n < RES_MAX);
  assign sts.y_more     = (y < dk) && (n < RES_MAX);
  assign sts.z_more     = (z < dl) && (n < RES_MAX);
  assign sts.rd_eq_a    = nb_rdata == a_q;
  assign sts.rd_eq_j    = nb_rdata == j_q;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

endmodule

### rtl/bgp_ctrl.sv
// Controller: sequences append, clear and the three-level query walk.
module bgp_ctrl
  import bgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_op,
  output logic       req_ready,
  output bgp_cmd_t   cmd,
  input  bgp_sts_t   sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_APP_CHK, S_APP_RD, S_RESP,
    S_Q_RD, S_Q_DJ, S_X, S_X_W, S_J_RD, S_J_DW,
    S_Y, S_Y_W, S_K_RD, S_K_DW, S_Z, S_Z_W, S_FIN
  } state_t;

  state_t state, state_next;
  logic   resp_status, resp_status_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Next state and command decode
  always_comb begin
    cmd              = '0;
    state_next       = state;
    resp_status_next = resp_status;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          case (op_t'(req_op))
            OP_APPEND: state_next = S_APP_CHK;
            OP_QUERY: begin
              cmd.clr_walk = 1'b1;
              state_next   = S_Q_RD;
            end
            OP_CLEAR: begin
              cmd.clr_all      = 1'b1;
              resp_status_next = 1'b0;
              state_next       = S_RESP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      // Append: range check, then read degree
      S_APP_CHK: begin
        if (!(sts.a_ok && sts.nb_ok)) begin
          resp_status_next = 1'b1;
          state_next       = S_RESP;
        end else begin
          cmd.deg_rd  = 1'b1;
          cmd.deg_sel = SEL_A;
          state_next  = S_APP_RD;
        end
      end
      S_APP_RD: begin
        if (sts.deg_full) begin
          resp_status_next = 1'b1;
        end else begin
          cmd.app_write    = 1'b1;
          resp_status_next = 1'b0;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.push        = 1'b1;
          cmd.push_status = resp_status;
          state_next      = S_IDLE;
        end
      end
      // Query: degree of the start atom
      S_Q_RD: begin
        cmd.deg_rd  = 1'b1;
        cmd.deg_sel = SEL_A;
        state_next  = S_Q_DJ;
      end
      S_Q_DJ: begin
        cmd.ld_dj  = 1'b1;
        state_next = S_X;
      end
      // First hop
      S_X: begin
        if (sts.x_more) begin
          cmd.nb_rd  = 1'b1;
          cmd.nb_sel = SEL_A;
          state_next = S_X_W;
        end else begin
          state_next = S_FIN;
        end
      end
      S_X_W: begin
        cmd.ld_j   = 1'b1;
        state_next = S_J_RD;
      end
      S_J_RD: begin
        cmd.deg_rd  = 1'b1;
        cmd.deg_sel = SEL_J;
        state_next  = S_J_DW;
      end
      S_J_DW: begin
        cmd.ld_dk  = 1'b1;
        state_next = S_Y;
      end
      // Second hop, skipping a return to the start atom
      S_Y: begin
        if (sts.y_more) begin
          cmd.nb_rd  = 1'b1;
          cmd.nb_sel = SEL_J;
          state_next = S_Y_W;
        end else begin
          cmd.inc_x  = 1'b1;
          state_next = S_X;
        end
      end
      S_Y_W: begin
        if (sts.rd_eq_a) begin
          cmd.inc_y  = 1'b1;
          state_next = S_Y;
        end else begin
          cmd.ld_k   = 1'b1;
          state_next = S_K_RD;
        end
      end
      S_K_RD: begin
        cmd.deg_rd  = 1'b1;
        cmd.deg_sel = SEL_K;
        state_next  = S_K_DW;
      end
      S_K_DW: begin
        cmd.ld_dl  = 1'b1;
        state_next = S_Z;
      end
      // Third hop
      S_Z: begin
        if (sts.z_more) begin
          cmd.nb_rd  = 1'b1;
          cmd.nb_sel = SEL_K;
          state_next = S_Z_W;
        end else begin
          cmd.inc_y  = 1'b1;
          state_next = S_Y;
        end
      end
      // New partner: release the held one (not last), hold the new one
      S_Z_W: begin
        if (sts.rd_eq_a || sts.rd_eq_j) begin
          cmd.inc_z  = 1'b1;
          state_next = S_Z;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push         = sts.pend_valid;
          cmd.push_partner = 1'b1;
          cmd.push_last    = 1'b0;
          cmd.take_l       = 1'b1;
          cmd.inc_z        = 1'b1;
          state_next       = S_Z;
        end
      end
      // End of walk: held partner goes out as last, else a not-found item
      S_FIN: begin
        if (sts.out_free) begin
          cmd.push         = 1'b1;
          cmd.push_partner = sts.pend_valid;
          cmd.push_last    = 1'b1;
          cmd.push_status  = 1'b0;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    resp_status <= resp_status_next;
  end

endmodule

### rtl/bond_graph_one_four_partners.sv
// Top level of the one-four bond partner finder.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, atom_index, neighbor_index
//   rsp      out  valid/ready    partner_index, found, status, last
//
// One item at a time: req is ready only while the sequencer is idle.
// A query walks the table with serial reads through the single neighbor-table
// read port: each first-hop neighbor, each second-hop neighbor (with no degree
// read when it is the start atom) and each third-hop entry is read in turn;
// the walk stops early at 36 partners.
// rsp is held in an output register; a stalled rsp holds the walk only when a
// new partner or final item must be pushed. Reset is synchronous and empties
// every list; no clearing pass is needed.
module bond_graph_one_four_partners
  import bgp_pkg::*;
#(
  parameter int ATOMS      = 256,
  parameter int MAX_DEGREE = 4
) (
  input  logic      clk,
  input  logic      rst,
  bgp_req_if.sink   req,
  bgp_rsp_if.source rsp
);

  bgp_cmd_t cmd;
  bgp_sts_t sts;

  bgp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bgp_dp #(
    .ATOMS      (ATOMS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_atom (req.atom_index),
    .req_nb   (req.neighbor_index),
    .rsp      (rsp)
  );

endmodule

### tb/sv/testbench.sv
// Testbench for the one-four bond partner finder: directed and random graph items.
module testbench
  import bgp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEGREE_MAX = 4;
  localparam int          PARTNER_CAP = 36;
  localparam logic [1:0]  OP_UNKNOWN = 2'd3;
  localparam int          TAIL_CYCLES = 64;

  typedef struct packed {
    logic [7:0] partner;
    logic       found;
    logic       status;
    logic       last;
  } rsp_item_t;

  logic clk;
  logic rst;

  bgp_req_if req_ch ();
  bgp_rsp_if rsp_ch ();

  bond_graph_one_four_partners #(
    .ATOMS      (256),
    .MAX_DEGREE (DEGREE_MAX)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Mirror of the adjacency table
  logic [2:0] deg_mirror  [256];
  logic [7:0] bond_mirror [256*DEGREE_MAX];

  rsp_item_t awaited_rsp [$];
  int        error_count;
  int        idle_pct;
  int        stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver back-pressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Response checker: compare each accepted item against the oldest expectation
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited_rsp.size() == 0) begin
        error_count++;
        $display("%0t unexpected item: partner=%0d found=%b status=%b last=%b",
                 $time, rsp_ch.partner_index, rsp_ch.found, rsp_ch.status, rsp_ch.last);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_ch.partner_index !== want.partner || rsp_ch.found !== want.found ||
            rsp_ch.status !== want.status || rsp_ch.last !== want.last) begin
          error_count++;
          $display("%0t mismatch: expected partner=%0d found=%b status=%b last=%b,",
                   $time, want.partner, want.found, want.status, want.last);
          $display("%0t   actual partner=%0d found=%b status=%b last=%b",
                   $time, rsp_ch.partner_index, rsp_ch.found, rsp_ch.status,
                   rsp_ch.last);
        end
      end
    end
  end

  // Append one expected item to the tail of the queue
  task automatic expect_rsp(input logic [7:0] partner, input logic found,
                            input logic status, input logic last);
    rsp_item_t item;
    item = '{partner: partner, found: found, status: status, last: last};
    awaited_rsp.insert(awaited_rsp.size(), item);
  endtask

  // Walk i -> j -> k -> l and queue the partners, up to PARTNER_CAP, in walk order
  task automatic walk_one_four(input logic [7:0] a);
    logic [7:0] hits [$];
    logic [7:0] j, k, l;
    for (int x = 0; x < deg_mirror[a] && hits.size() < PARTNER_CAP; x++) begin
      j = bond_mirror[a*DEGREE_MAX + x];
      for (int y = 0; y < deg_mirror[j] && hits.size() < PARTNER_CAP; y++) begin
        k = bond_mirror[j*DEGREE_MAX + y];
        if (k == a) continue;
        for (int z = 0; z < deg_mirror[k] && hits.size() < PARTNER_CAP; z++) begin
          l = bond_mirror[k*DEGREE_MAX + z];
          if (l == a || l == j) continue;
          hits.insert(hits.size(), l);
        end
      end
    end
    if (hits.size() == 0)
      expect_rsp(8'd0, 1'b0, 1'b0, 1'b1);
    else
      foreach (hits[i])
        expect_rsp(hits[i], 1'b1, 1'b0, (i == hits.size() - 1));
  endtask

  // Update the mirror and queue what one accepted item must produce
  task automatic predict_item(input logic [1:0] op, input logic [7:0] a,
                              input logic [7:0] nb);
    logic full;
    case (op)
      OP_APPEND: begin
        // atom indices are 8 bits wide, so they are always in range here
        full = (deg_mirror[a] >= DEGREE_MAX);
        if (!full) begin
          bond_mirror[a*DEGREE_MAX + deg_mirror[a]] = nb;
          deg_mirror[a] = deg_mirror[a] + 3'd1;
        end
        expect_rsp(8'd0, 1'b0, full, 1'b1);
      end
      OP_CLEAR: begin
        foreach (deg_mirror[i]) deg_mirror[i] = 3'd0;
        expect_rsp(8'd0, 1'b0, 1'b0, 1'b1);
      end
      OP_QUERY: walk_one_four(a);
      default: ;  // unknown operation: no effect, no item
    endcase
  endtask

  // Offer one request item after a random gap and wait until it is taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] a,
                           input logic [7:0] nb);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= op;
    req_ch.atom_index     <= a;
    req_ch.neighbor_index <= nb;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_item(op, a, nb);
  endtask

  // Hold the sender until every expected item has come back
  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // Empty table, extreme indices and the unknown operation
  task automatic test_empty_and_unknown;
    send_item(OP_QUERY, 8'd0, 8'd255);
    send_item(OP_QUERY, 8'd255, 8'd0);
    send_item(OP_UNKNOWN, 8'd255, 8'd255);
    send_item(OP_CLEAR, 8'd255, 8'd255);
  endtask

  // Chain 0-255-1-2: the walk must skip k == i and l == j
  task automatic test_chain_skips;
    send_item(OP_APPEND, 8'd0, 8'd255);
    send_item(OP_APPEND, 8'd255, 8'd0);
    send_item(OP_APPEND, 8'd255, 8'd1);
    send_item(OP_APPEND, 8'd1, 8'd255);
    send_item(OP_APPEND, 8'd1, 8'd2);
    send_item(OP_APPEND, 8'd2, 8'd1);
    send_item(OP_QUERY, 8'd0, 8'd0);
    send_item(OP_QUERY, 8'd2, 8'd0);
    send_item(OP_QUERY, 8'd255, 8'd0);
  endtask

  // Full lists with duplicates: overflow on append, 64 partners cut to 36
  task automatic test_full_and_truncation;
    send_item(OP_CLEAR, 8'd0, 8'd0);
    repeat (DEGREE_MAX) send_item(OP_APPEND, 8'd10, 8'd20);
    repeat (DEGREE_MAX) send_item(OP_APPEND, 8'd20, 8'd30);
    repeat (DEGREE_MAX) send_item(OP_APPEND, 8'd30, 8'd40);
    send_item(OP_APPEND, 8'd10, 8'd99);
    send_item(OP_QUERY, 8'd10, 8'd0);
  endtask

  // Random small molecules: build bonds on a pool of atoms, then query them
  task automatic test_random_graphs(input int idle, input int stall, input int budget);
    int         sent;
    int         pool_n;
    int         pick;
    logic [7:0] pool [10];
    logic [7:0] u, v;
    sent      = 0;
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < budget) begin
      if ($urandom_range(3) != 0) begin
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom));
        sent++;
      end
      pool_n = $urandom_range(10, 3);
      for (int i = 0; i < pool_n; i++) pool[i] = 8'($urandom);
      // bonds, mostly recorded in both directions
      repeat ($urandom_range(pool_n * 2, pool_n)) begin
        u = pool[$urandom_range(pool_n - 1)];
        v = pool[$urandom_range(pool_n - 1)];
        send_item(OP_APPEND, u, v);
        sent++;
        if ($urandom_range(4) != 0) begin
          send_item(OP_APPEND, v, u);
          sent++;
        end
      end
      // queries with some noise mixed in
      repeat ($urandom_range(8, 3)) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          send_item(OP_QUERY, 8'($urandom), 8'($urandom));
          sent++;
        end else if (pick == 1) begin
          send_item(OP_UNKNOWN, 8'($urandom), 8'($urandom));
        end else if (pick == 2) begin
          send_item(OP_APPEND, 8'($urandom), 8'($urandom));
          sent++;
        end else begin
          send_item(OP_QUERY, pool[$urandom_range(pool_n - 1)], 8'($urandom));
          sent++;
        end
      end
    end
    drain();
  endtask

  // Test sequence
  initial begin
    error_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    foreach (deg_mirror[i]) deg_mirror[i] = 3'd0;
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.operation      <= OP_APPEND;
    req_ch.atom_index     <= 8'd0;
    req_ch.neighbor_index <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_unknown();
    test_chain_skips();
    test_full_and_truncation();
    drain();

    test_random_graphs(0, 0, 95);
    test_random_graphs(82, 0, 95);
    test_random_graphs(0, 82, 95);
    test_random_graphs(28, 28, 95);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_rsp.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
